/* sv/fault_code_debounce_table_assert.svh */
// ----------------------------------------------------------------------------
// fault_code_debounce_table_assert.svh
// assertion macros used by the debounce table datapath (fcdt_dp)
// ----------------------------------------------------------------------------
`ifndef FAULT_CODE_DEBOUNCE_TABLE_ASSERT_SVH
`define FAULT_CODE_DEBOUNCE_TABLE_ASSERT_SVH

// property that must hold at every edge out of reset
`define FCDT_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define FCDT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/fcdt_pkg.sv */
// ----------------------------------------------------------------------------
// fcdt_pkg
// types, constants and helpers of the fault code debounce table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcdt_pkg;

  localparam int unsigned FCDT_ENTRIES = 16;
  localparam int unsigned CFG_AW       = 2;
  localparam int unsigned CFG_DW       = 4;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned SEV_W        = 3;

  localparam logic [CNT_W-1:0] CNT_MAX        = 4'hF;
  localparam logic [CNT_W-1:0] RST_FAULT_LIM  = 4'd3;
  localparam logic [CNT_W-1:0] RST_HEAL_LIM   = 4'd3;
  localparam logic [SEV_W-1:0] RST_CRIT_LEVEL = 3'd3;

  typedef enum logic [CFG_AW-1:0] {
    CFG_FAULT_LIMIT = 2'd0,
    CFG_HEAL_LIMIT  = 2'd1,
    CFG_CRIT_LEVEL  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_REPORT = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } fcdt_state_e;

  typedef struct packed {
    logic              operation;
    logic [CODE_W-1:0] fault_code;
    logic              fault_seen;
    logic [SEV_W-1:0]  severity;
  } in_req_t;

  typedef struct packed {
    logic              status;
    logic              raise_event;
    logic              clear_event;
    logic [CODE_W-1:0] code_out;
  } out_rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] fault_limit;
    logic [CNT_W-1:0] heal_limit;
    logic [SEV_W-1:0] critical_level;
  } cfg_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  fault_cnt;
    logic [CNT_W-1:0]  heal_cnt;
    logic              active;
  } entry_t;

  typedef struct packed {
    logic load;
    logic search;
    logic finish;
  } fcdt_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic hit;
    logic miss;
    logic out_busy;
  } fcdt_sts_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 4'd1;
  endfunction

endpackage

/* sv/fcdt_ctrl.sv */
// ----------------------------------------------------------------------------
// fcdt_ctrl
// sequencer: takes a request, walks the table search, then writes back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcdt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fcdt_pkg::fcdt_sts_t sts_i,
  output fcdt_pkg::fcdt_cmd_t cmd_o
);
  import fcdt_pkg::*;

  fcdt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (sts_i.op_clear || sts_i.hit || sts_i.miss) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.load  = in_valid_i;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
      end
      ST_FINISH: begin
        // result register must be free before the write-back
        cmd_o.finish = !sts_i.out_busy;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

/* sv/fcdt_dp.sv */
// ----------------------------------------------------------------------------
// fcdt_dp
// datapath: request register, entry memory, search pointer, update logic
// and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcdt_dp #(
  parameter int unsigned ENTRIES = fcdt_pkg::FCDT_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcdt_pkg::cfg_t      cfg_i,
  input  fcdt_pkg::in_req_t   in_req_i,
  input  fcdt_pkg::fcdt_cmd_t cmd_i,
  output fcdt_pkg::fcdt_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcdt_pkg::out_rsp_t  out_rsp_o
);
  import fcdt_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  entry_t mem [ENTRIES];

  in_req_t        req_q;
  logic [CW-1:0]  idx_q;
  logic [CW-1:0]  cmp_idx_q;
  logic           cmp_vld_q;
  entry_t         rd_q;
  logic           found_q;
  entry_t         ent_q;
  logic [AW-1:0]  hit_idx_q;
  logic [CW-1:0]  used_q, used_d;
  logic           out_valid_q;
  out_rsp_t       out_rsp_q;

  logic           idx_at_end;
  logic           rd_en;
  logic           hit;
  logic           full;
  logic           op_clear;
  logic           alloc;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  entry_t         wr_ent;
  out_rsp_t       rsp;
  logic [CNT_W-1:0] f_inc, h_inc;

  assign op_clear   = (req_q.operation == OP_CLEAR);
  assign idx_at_end = (idx_q == used_q);
  assign rd_en      = cmd_i.search && !op_clear && !idx_at_end;
  assign hit        = cmp_vld_q && (rd_q.code == req_q.fault_code);
  assign full       = (used_q == FULL_CNT);

  assign sts_o.op_clear = op_clear;
  assign sts_o.hit      = hit;
  // nothing left to read and the last compare did not match
  assign sts_o.miss     = idx_at_end && !hit;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  // request capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      cmp_vld_q <= rd_en;
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (rd_en) idx_q <= idx_q + 1'b1;
        if (cmd_i.search && hit) found_q <= 1'b1;
      end
    end
  end

  // table memory, registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q      <= mem[idx_q[AW-1:0]];
      cmp_idx_q <= idx_q;
    end
    if (wr_en) mem[wr_addr] <= wr_ent;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search && hit) begin
      ent_q     <= rd_q;
      hit_idx_q <= cmp_idx_q[AW-1:0];
    end
  end

  // entry update and result
  assign f_inc = sat_inc(ent_q.fault_cnt);
  assign h_inc = sat_inc(ent_q.heal_cnt);

  always_comb begin
    wr_ent           = ent_q;
    rsp.status       = 1'b0;
    rsp.raise_event  = 1'b0;
    rsp.clear_event  = 1'b0;
    rsp.code_out     = req_q.fault_code;
    wr_addr          = used_q[AW-1:0];
    priority if (op_clear) begin
      rsp.code_out = '0;
    end else if (found_q) begin
      wr_addr = hit_idx_q;
      if (req_q.fault_seen) begin
        wr_ent.fault_cnt = f_inc;
        wr_ent.heal_cnt  = '0;
        if ((f_inc > cfg_i.fault_limit) && !ent_q.active) begin
          wr_ent.active   = 1'b1;
          rsp.raise_event = 1'b1;
        end
      end else begin
        wr_ent.heal_cnt  = h_inc;
        wr_ent.fault_cnt = '0;
        if ((h_inc > cfg_i.heal_limit) && ent_q.active) begin
          wr_ent.active   = 1'b0;
          rsp.clear_event = 1'b1;
        end
      end
    end else if (!full) begin
      // new code takes the next free entry
      wr_ent.code      = req_q.fault_code;
      wr_ent.fault_cnt = req_q.fault_seen ? 4'd1 : 4'd0;
      wr_ent.heal_cnt  = req_q.fault_seen ? 4'd0 : 4'd1;
      wr_ent.active    = (req_q.severity == cfg_i.critical_level);
      rsp.raise_event  = wr_ent.active;
    end else begin
      rsp.status = 1'b1;
    end
  end

  assign wr_en = cmd_i.finish && !op_clear && (found_q || !full);
  assign alloc = cmd_i.finish && !op_clear && !found_q && !full;

  always_comb begin
    used_d = used_q;
    if (cmd_i.finish) begin
      if (op_clear) begin
        used_d = '0;
      end else if (!found_q && !full) begin
        used_d = used_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      used_q <= used_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) out_rsp_q <= rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`include "fault_code_debounce_table_assert.svh"

  `FCDT_ASSERT_NOW(a_used_bound, used_q <= FULL_CNT, "used entry count beyond table size")
  `FCDT_ASSERT_IMPL(a_hit_in_range, hit, cmp_idx_q < used_q, "match on an unused entry")
  `FCDT_ASSERT_NEXT(a_clear_empties, cmd_i.finish && op_clear, used_q == '0, "clear left entries")
  `FCDT_ASSERT_NEXT(a_alloc_grows, alloc, used_q == $past(used_q) + 1'b1, "no entry taken")

endmodule

/* sv/fault_code_debounce_table.sv */
// ----------------------------------------------------------------------------
// fault_code_debounce_table
// counter-based fault debounce over a table of diagnostic trouble codes
// ----------------------------------------------------------------------------
// One request at a time. After a request is taken, the table is searched one
// entry per clock through the registered read port of the entry memory, then
// the FINISH state writes the entry back, unless the request is a clear or the
// table is full and the code new, and loads the result register. The search
// stops at the first matching entry; a clear request reads no entry. The next
// request is taken while a result still waits on out_stall_i; only the
// write-back waits for the result register.
// Table contents need no clearing after reset: only entries below the use
// count are ever read.
`timescale 1ns / 1ps

module fault_code_debounce_table #(
  parameter int unsigned ENTRIES = fcdt_pkg::FCDT_ENTRIES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fcdt_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [fcdt_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  fcdt_pkg::in_req_t            in_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output fcdt_pkg::out_rsp_t           out_rsp_o
);
  import fcdt_pkg::*;

  cfg_t      cfg_q;
  fcdt_cmd_t cmd;
  fcdt_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fault_limit    <= RST_FAULT_LIM;
      cfg_q.heal_limit     <= RST_HEAL_LIM;
      cfg_q.critical_level <= RST_CRIT_LEVEL;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_FAULT_LIMIT: cfg_q.fault_limit    <= cfg_wdata_i;
        CFG_HEAL_LIMIT:  cfg_q.heal_limit     <= cfg_wdata_i;
        CFG_CRIT_LEVEL:  cfg_q.critical_level <= cfg_wdata_i[SEV_W-1:0];
        default: begin
          // unmapped index, write ignored
        end
      endcase
    end
  end

  fcdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcdt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
